FILE: rtl/vdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdl_pkg: shared constants and types of the voxel density limiter.
// Holds field widths, table geometry, register indexes and the hash step.
// ----------------------------------------------------------------------------
package vdl_pkg;
    localparam int CoordW     = 24;
    localparam int InvW       = 20;
    localparam int CapW       = 8;
    localparam int IndexBits  = 16;
    localparam int TableDepth = 4096;
    localparam int AddrW      = $clog2(TableDepth);
    localparam int ProbeLimit = 8;
    localparam int ProbeW     = $clog2(ProbeLimit + 1);
    localparam int ProdW      = CoordW + InvW + 1;
    localparam int EntryW     = 1 + 3 * IndexBits + CapW;
    localparam int CfgIdxW    = 1;
    localparam logic [CfgIdxW-1:0] REG_INV_VOXEL = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_MAX_POINTS = 1'd1;
    localparam logic [InvW-1:0] INV_RESET = 20'd1311;
    localparam logic [CapW-1:0] CAP_RESET = 8'd20;
    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    typedef logic signed [IndexBits-1:0] vidx_t;

    typedef struct packed {
        logic              valid;
        vidx_t             kx;
        vidx_t             ky;
        vidx_t             kz;
        logic [CapW-1:0]   count;
    } entry_t;

    typedef struct packed {
        vidx_t ix;
        vidx_t iy;
        vidx_t iz;
        logic [AddrW-1:0] home;
    } key_t;

    function automatic logic [31:0] mix(input logic [31:0] h, input vidx_t k);
        logic [31:0] ke;
        ke = {{(32 - IndexBits){k[IndexBits-1]}}, k};
        return h ^ (ke + GOLDEN + (h << 6) + (h >> 2));
    endfunction
endpackage
`default_nettype wire

FILE: rtl/voxel_density_limiter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_density_limiter: caps the number of map points per voxel.
// Quantises a point to a voxel key, probes a hashed count table, updates it.
// ----------------------------------------------------------------------------
// Points enter on the s_axis channel; one result item per point leaves on
// m_axis, carrying the accepted and table_full flags, the voxel fill count
// and the coordinates passed through. Registers are written on the cfg
// channel; the user must write them only while the block is idle, as the
// block itself does not enforce it. One point is processed at a time.
// Key generation comes first; each probe of the count table then passes
// through a memory read state and a compare and write back state, for
// each of the slots probed (1 to 8). After reset a clearing pass writes
// every table entry invalid, one a cycle, during which s_axis_tready
// stays low. A result is held in an output register; while the receiver
// stalls it waits there and a new point is taken only once it has gone.
// ----------------------------------------------------------------------------
module voxel_density_limiter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // point_x, point_y, point_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // accepted, voxel_fill, table_full, out_x,y,z, pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [vdl_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int AW = vdl_pkg::AddrW;
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_KEY   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic [vdl_pkg::InvW-1:0] inv_reg;
    logic [vdl_pkg::CapW-1:0] cap_reg;
    logic [71:0] pt_reg;
    vdl_pkg::key_t key_reg;
    logic [AW-1:0] slot_reg;
    logic [vdl_pkg::ProbeW-1:0] probe_reg;
    logic acc_reg, full_reg;
    logic [vdl_pkg::CapW-1:0] fill_reg;
    logic q_start, q_done;
    vdl_pkg::key_t q_key;
    vdl_pkg::entry_t rd_data, wr_data;
    logic wr_en, hit;
    logic [AW-1:0] wr_addr;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign q_start       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {6'd0, pt_reg, full_reg, fill_reg, acc_reg};

    vdl_quant u_quant (
        .aclk(aclk), .aresetn(aresetn), .start(q_start),
        .px(s_axis_tdata[23:0]), .py(s_axis_tdata[47:24]), .pz(s_axis_tdata[71:48]),
        .inv(inv_reg), .done(q_done), .key(q_key)
    );

    assign hit = !rd_data.valid || (rd_data.kx == key_reg.ix &&
                 rd_data.ky == key_reg.iy && rd_data.kz == key_reg.iz);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_data = rd_data;
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end else if (state_reg == ST_CHECK && hit) begin
            wr_en = 1'b1;
            wr_data.valid = 1'b1;
            wr_data.kx = key_reg.ix;
            wr_data.ky = key_reg.iy;
            wr_data.kz = key_reg.iz;
            if (!rd_data.valid) begin
                wr_data.count = (cap_reg != '0) ? 8'd1 : 8'd0;
            end else if (rd_data.count < cap_reg) begin
                wr_data.count = rd_data.count + 8'd1;
            end
        end
    end

    vdl_table u_table (
        .aclk(aclk), .rd_en(state_reg == ST_READ), .rd_addr(slot_reg),
        .rd_data(rd_data), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == AW'(vdl_pkg::TableDepth - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (q_start) state_next = ST_KEY;
            ST_KEY:   if (q_done) state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: begin
                if (hit || probe_reg == vdl_pkg::ProbeW'(vdl_pkg::ProbeLimit - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_start) pt_reg <= s_axis_tdata;
        if (state_reg == ST_KEY && q_done) begin
            key_reg   <= q_key;
            slot_reg  <= q_key.home;
            probe_reg <= '0;
        end
        if (state_reg == ST_CHECK) begin
            if (hit) begin
                acc_reg  <= (wr_data.count != rd_data.count) || (!rd_data.valid && cap_reg != '0);
                fill_reg <= wr_data.count;
                full_reg <= 1'b0;
            end else begin
                acc_reg   <= 1'b0;
                fill_reg  <= '0;
                full_reg  <= 1'b1;
                slot_reg  <= slot_reg + AW'(1);
                probe_reg <= probe_reg + vdl_pkg::ProbeW'(1);
            end
        end
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            inv_reg   <= vdl_pkg::INV_RESET;
            cap_reg   <= vdl_pkg::CAP_RESET;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (cfg_valid) begin
                if (cfg_index == vdl_pkg::REG_INV_VOXEL) inv_reg <= cfg_data[vdl_pkg::InvW-1:0];
                if (cfg_index == vdl_pkg::REG_MAX_POINTS) cap_reg <= cfg_data[vdl_pkg::CapW-1:0];
            end
        end
    end

`ifndef SYNTHESIS
    a_no_input_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid) else $error("input ready while result pending");
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8:1] == 8'd0 && !m_axis_tdata[0])
        else $error("table full with nonzero fill");
    a_acc_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[8:1] <= cap_reg
                                             && m_axis_tdata[8:1] != 8'd0)
        else $error("accepted beyond cap");
`endif
endmodule
`default_nettype wire

FILE: rtl/vdl_quant.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdl_quant: voxel key unit.
// One multiply per axis, register, floor and saturate, register, then hash.
// ----------------------------------------------------------------------------
module vdl_quant (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic signed [vdl_pkg::CoordW-1:0]  px,
    input  wire logic signed [vdl_pkg::CoordW-1:0]  py,
    input  wire logic signed [vdl_pkg::CoordW-1:0]  pz,
    input  wire logic [vdl_pkg::InvW-1:0]           inv,
    output logic                                    done,
    output vdl_pkg::key_t                           key
);
    localparam int PW = vdl_pkg::ProdW;
    localparam int IB = vdl_pkg::IndexBits;

    logic signed [PW-1:0] prod_reg [3];
    logic [2:0] vld_reg;
    vdl_pkg::vidx_t q_reg [3];
    logic signed [vdl_pkg::CoordW-1:0] pin [3];
    vdl_pkg::vidx_t qn [3];
    logic [31:0] h;

    assign pin[0] = px;
    assign pin[1] = py;
    assign pin[2] = pz;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [PW-17:0] fl;
            fl = prod_reg[a][PW-1:16];
            if (fl > $signed({{(PW-16-IB){1'b0}}, 1'b0, {(IB-1){1'b1}}})) begin
                qn[a] = {1'b0, {(IB-1){1'b1}}};
            end else if (fl < $signed({{(PW-16-IB){1'b1}}, 1'b1, {(IB-1){1'b0}}})) begin
                qn[a] = {1'b1, {(IB-1){1'b0}}};
            end else begin
                qn[a] = fl[IB-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            prod_reg[a] <= $signed(PW'(pin[a])) * $signed(PW'({1'b0, inv}));
            q_reg[a]    <= qn[a];
        end
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    assign h = vdl_pkg::mix(vdl_pkg::mix({{(32-IB){q_reg[0][IB-1]}}, q_reg[0]},
                                         q_reg[1]), q_reg[2]);
    assign done     = vld_reg[1];
    assign key.ix   = q_reg[0];
    assign key.iy   = q_reg[1];
    assign key.iz   = q_reg[2];
    assign key.home = h[vdl_pkg::AddrW-1:0];
endmodule
`default_nettype wire

FILE: rtl/vdl_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdl_table: voxel count table.
// Single-port-write, registered-read memory of table entries.
// ----------------------------------------------------------------------------
module vdl_table (
    input  wire logic                        aclk,
    input  wire logic                        rd_en,
    input  wire logic [vdl_pkg::AddrW-1:0]   rd_addr,
    output vdl_pkg::entry_t                  rd_data,
    input  wire logic                        wr_en,
    input  wire logic [vdl_pkg::AddrW-1:0]   wr_addr,
    input  wire vdl_pkg::entry_t             wr_data
);
    vdl_pkg::entry_t mem [vdl_pkg::TableDepth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire
